### rtl/ifa_pkg.sv
// Package for the integer to ascii formatter: format codes, sequencer states,
// ascii constants and character helper functions.
// No dependencies.
package ifa_pkg;

  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_HEX  = 2'd2,
    CMD_PTR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned VAL_W      = 32;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_LOW_A = 7'h61;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_LPAR  = 7'h28;
  localparam logic [6:0] CH_RPAR  = 7'h29;
  localparam logic [6:0] CH_N     = 7'h6E;
  localparam logic [6:0] CH_I     = 7'h69;
  localparam logic [6:0] CH_L     = 7'h6C;

  localparam logic [3:0] NIL_LEN = 4'd5;

  // lower-case hex digit, also covers bcd digits
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {3'b000, nib};
    end else begin
      c = CH_LOW_A + {3'b000, nib - 4'd10};
    end
    return c;
  endfunction

  function automatic logic [6:0] nil_char(input logic [2:0] idx);
    logic [6:0] c;
    case (idx)
      3'd0:    c = CH_LPAR;
      3'd1:    c = CH_N;
      3'd2:    c = CH_I;
      3'd3:    c = CH_L;
      default: c = CH_RPAR;
    endcase
    return c;
  endfunction

endpackage

### rtl/integer_to_ascii_formatter.sv
// Integer to ascii formatter top level: shift-and-add-3 binary to bcd unit,
// digit sizing and a character emitter with an output register.
// Depends on ifa_pkg.
//
// Usage: one input beat (cmd, value, alt_prefix) on in_valid/in_ready yields
// one to eleven output beats (char_out, last) on out_valid/out_ready, most
// significant character first, last high on the final one.
// in_ready is high only while the sequencer is idle; one item is in work at
// a time.
// Decimal commands run the magnitude through a shared shift-and-add-3 step,
// one bit per cycle in ST_CONV, then ST_SIZE sizes the digit string before
// ST_EMIT registers the first character.
// Hex and pointer skip the conversion and go straight to ST_SIZE.
// Characters then leave at one per cycle while out_ready stays high.
// The next input beat is taken while the last character still waits in the
// output register.
// When the receiver stalls, the output register holds and the emitter waits.
// Reset returns the sequencer to idle and drops out_valid.
module integer_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] value,
  input  logic        alt_prefix,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  char_out,
  output logic        last
);

  ifa_pkg::state_t state, state_next;

  ifa_pkg::cmd_t cmd_q;
  logic          neg;
  logic          nz;
  logic          alt_q;
  logic [31:0]   mag;
  logic [ifa_pkg::NUM_DIGITS-1:0][3:0] dig;
  logic [4:0]    cnt;
  logic [3:0]    nd;
  logic [3:0]    k;

  logic [ifa_pkg::NUM_DIGITS-1:0][3:0] adj;
  logic [3:0]    nd_calc;
  logic [1:0]    pre_len;
  logic          is_nil;
  logic [3:0]    n_chars;
  logic [3:0]    k_dig;
  logic [3:0]    pos;
  logic [6:0]    ch;
  logic          ch_last;
  logic          emit_go;
  logic          in_fire;

  assign in_ready = (state == ifa_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < ifa_pkg::NUM_DIGITS; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
  end

  // digit count: highest nonzero digit, at least one; pointers always use eight
  always_comb begin
    nd_calc = 4'd1;
    for (int i = 0; i < ifa_pkg::NUM_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        nd_calc = 4'(i + 1);
      end
    end
    if (cmd_q == ifa_pkg::CMD_PTR) begin
      nd_calc = 4'd8;
    end
  end

  always_comb begin
    is_nil  = (cmd_q == ifa_pkg::CMD_PTR) && !nz;
    pre_len = 2'd0;
    case (cmd_q)
      ifa_pkg::CMD_SDEC: pre_len = neg ? 2'd1 : 2'd0;
      ifa_pkg::CMD_HEX:  pre_len = (alt_q && nz) ? 2'd2 : 2'd0;
      ifa_pkg::CMD_PTR:  pre_len = nz ? 2'd2 : 2'd0;
      default:           pre_len = 2'd0;
    endcase
    n_chars = is_nil ? ifa_pkg::NIL_LEN : nd + {2'b00, pre_len};
    k_dig   = k - {2'b00, pre_len};
    pos     = nd - 4'd1 - k_dig;
    if (is_nil) begin
      ch = ifa_pkg::nil_char(k[2:0]);
    end else if (k < {2'b00, pre_len}) begin
      if (k == 4'd0) begin
        ch = neg ? ifa_pkg::CH_MINUS : ifa_pkg::CH_ZERO;
      end else begin
        ch = ifa_pkg::CH_X;
      end
    end else if (pos < 4'(ifa_pkg::NUM_DIGITS)) begin
      ch = ifa_pkg::hex_char(dig[pos]);
    end else begin
      ch = ifa_pkg::CH_ZERO;
    end
    ch_last = (k == n_chars - 4'd1);
  end

  assign emit_go = (state == ifa_pkg::ST_EMIT) && (!out_valid || out_ready);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ifa_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (cmd == ifa_pkg::CMD_SDEC || cmd == ifa_pkg::CMD_UDEC) begin
            state_next = ifa_pkg::ST_CONV;
          end else begin
            state_next = ifa_pkg::ST_SIZE;
          end
        end
      end
      ifa_pkg::ST_CONV: begin
        if (cnt == 5'd31) begin
          state_next = ifa_pkg::ST_SIZE;
        end
      end
      ifa_pkg::ST_SIZE: state_next = ifa_pkg::ST_EMIT;
      ifa_pkg::ST_EMIT: begin
        if (emit_go && ch_last) begin
          state_next = ifa_pkg::ST_IDLE;
        end
      end
      default: state_next = ifa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ifa_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_q <= ifa_pkg::cmd_t'(cmd);
          alt_q <= alt_prefix;
          nz    <= (value != 32'd0);
          neg   <= (cmd == ifa_pkg::CMD_SDEC) && value[31];
          mag   <= ((cmd == ifa_pkg::CMD_SDEC) && value[31]) ? 32'd0 - value : value;
          cnt   <= 5'd0;
          k     <= 4'd0;
          if (cmd == ifa_pkg::CMD_SDEC || cmd == ifa_pkg::CMD_UDEC) begin
            dig <= '0;
          end else begin
            dig <= {8'h00, value};
          end
        end
      end
      ifa_pkg::ST_CONV: begin
        // shift the corrected bcd string left, next magnitude bit enters at the bottom
        dig <= {adj[ifa_pkg::NUM_DIGITS-1][2:0], adj[ifa_pkg::NUM_DIGITS-2:0], mag[31]};
        mag <= {mag[30:0], 1'b0};
        cnt <= cnt + 5'd1;
      end
      ifa_pkg::ST_SIZE: begin
        nd <= nd_calc;
      end
      ifa_pkg::ST_EMIT: begin
        if (emit_go) begin
          k <= k + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      char_out <= ch;
      last     <= ch_last;
    end
  end

endmodule

### verif/integer_to_ascii_formatter_test.sv
// Self-checking testbench for integer_to_ascii_formatter: directed table then random values,
// every character beat compared against the directed table text or a built-in formatter model.
// Depends on ifa_pkg and the integer_to_ascii_formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;

  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_beat_t;

  typedef struct {
    ifa_pkg::cmd_t c;
    logic [31:0]   v;
    logic          alt;
    string         text;  // empty: take the predicted string
  } format_case_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = ifa_pkg::CMD_SDEC;
  logic [31:0] value = '0;
  logic        alt_prefix = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  char_out;
  logic        last;

  char_beat_t  expected_chars[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  int          chars_checked = 0;
  int          items_per_cmd [4] = '{0, 0, 0, 0};
  int          quiet_cycles = 0;

  int unsigned decade [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
                               100000000, 1000000000};

  format_case_t directed_cases [20] = '{
    '{ifa_pkg::CMD_SDEC, 32'h0000_0000, 1'b0, "0"},
    '{ifa_pkg::CMD_SDEC, 32'h8000_0000, 1'b1, "-2147483648"},
    '{ifa_pkg::CMD_SDEC, 32'h7fff_ffff, 1'b0, "2147483647"},
    '{ifa_pkg::CMD_SDEC, 32'hffff_ffff, 1'b0, "-1"},
    '{ifa_pkg::CMD_UDEC, 32'h0000_0000, 1'b1, "0"},
    '{ifa_pkg::CMD_UDEC, 32'hffff_ffff, 1'b0, "4294967295"},
    '{ifa_pkg::CMD_UDEC, 32'd1000000000, 1'b0, "1000000000"},
    '{ifa_pkg::CMD_HEX,  32'h0000_0000, 1'b1, "0"},
    '{ifa_pkg::CMD_HEX,  32'h0000_0000, 1'b0, "0"},
    '{ifa_pkg::CMD_HEX,  32'hffff_ffff, 1'b1, "0xffffffff"},
    '{ifa_pkg::CMD_HEX,  32'hdead_beef, 1'b0, "deadbeef"},
    '{ifa_pkg::CMD_HEX,  32'h0000_000a, 1'b1, "0xa"},
    '{ifa_pkg::CMD_PTR,  32'h0000_0000, 1'b1, "(nil)"},
    '{ifa_pkg::CMD_PTR,  32'h0000_0001, 1'b0, "0x00000001"},
    '{ifa_pkg::CMD_PTR,  32'hffff_ffff, 1'b1, "0xffffffff"},
    '{ifa_pkg::CMD_SDEC, 32'd12345,     1'b1, ""},
    '{ifa_pkg::CMD_UDEC, 32'h1234_5678, 1'b1, ""},
    '{ifa_pkg::CMD_HEX,  32'h0010_0000, 1'b0, ""},
    '{ifa_pkg::CMD_PTR,  32'h00ab_cdef, 1'b0, ""},
    '{ifa_pkg::CMD_SDEC, 32'hffff_fff6, 1'b0, ""}
  };

  integer_to_ascii_formatter DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .value      (value),
    .alt_prefix (alt_prefix),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [6:0] digit_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ifa_pkg::CH_ZERO + 7'(nib);
    end
    return ifa_pkg::CH_LOW_A + 7'(nib - 4'd10);
  endfunction

  // queue the characters one formatted value should produce
  function automatic void predict_chars(input ifa_pkg::cmd_t c, input logic [31:0] v,
                                        input logic alt);
    logic [6:0]  text [12];
    logic [6:0]  rev [10];
    logic [31:0] mag;
    int          n;
    int          nd;
    int          pad_width;
    int          i;
    n = 0;
    case (c)
      ifa_pkg::CMD_SDEC, ifa_pkg::CMD_UDEC: begin
        mag = v;
        if (c == ifa_pkg::CMD_SDEC && v[31]) begin
          text[n] = ifa_pkg::CH_MINUS;
          n++;
          mag = 32'd0 - v;
        end
        nd = 0;
        do begin
          rev[nd] = digit_char(4'(mag % 10));
          mag = mag / 10;
          nd++;
        end while (mag != 0);
        for (i = nd - 1; i >= 0; i--) begin
          text[n] = rev[i];
          n++;
        end
      end
      default: begin
        if (c == ifa_pkg::CMD_PTR && v == 0) begin
          text[0] = ifa_pkg::CH_LPAR;
          text[1] = ifa_pkg::CH_N;
          text[2] = ifa_pkg::CH_I;
          text[3] = ifa_pkg::CH_L;
          text[4] = ifa_pkg::CH_RPAR;
          n = 5;
        end else begin
          // pointer pads to eight digits, hex only prefixes nonzero values
          pad_width = (c == ifa_pkg::CMD_PTR) ? 8 : 1;
          if (c == ifa_pkg::CMD_PTR || (alt && v != 0)) begin
            text[0] = ifa_pkg::CH_ZERO;
            text[1] = ifa_pkg::CH_X;
            n = 2;
          end
          nd = 8;
          while (nd > pad_width && v[4*(nd-1) +: 4] == 4'h0) nd--;
          for (i = nd - 1; i >= 0; i--) begin
            text[n] = digit_char(v[4*i +: 4]);
            n++;
          end
        end
      end
    endcase
    for (i = 0; i < n; i++) begin
      expected_chars.push_back('{ch: text[i], last: (i == n - 1)});
    end
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(7))
      0: v = $urandom_range(20);
      1: v = decade[$urandom_range(9)] + $urandom_range(2) - 1;
      2: v = 32'd0 - $urandom_range(1, 20);
      3: v = $urandom >> $urandom_range(31);
      4: begin
        case ($urandom_range(3))
          0: v = 32'h0000_0000;
          1: v = 32'h8000_0000;
          2: v = 32'h7fff_ffff;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // offer one beat, return once it is taken; valid stays up between back-to-back beats
  task automatic send_format(input ifa_pkg::cmd_t c, input logic [31:0] v, input logic alt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    value      <= v;
    alt_prefix <= alt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_per_cmd[c]++;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // character checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: char_out %h last %b", char_out, last);
        mismatches++;
      end else begin
        char_beat_t exp_beat;
        exp_beat = expected_chars.pop_front();
        if (char_out !== exp_beat.ch) begin
          $error("char_out: expected %h, got %h", exp_beat.ch, char_out);
          mismatches++;
        end
        if (last !== exp_beat.last) begin
          $error("last: expected %b, got %b", exp_beat.last, last);
          mismatches++;
        end
        chars_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    ifa_pkg::cmd_t rc;
    logic [31:0]   rv;
    logic          ra;
    int            i;
    int            k;
    send_idle_pct = 23;
    recv_idle_pct = 69;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_cases[i]) begin
      send_format(directed_cases[i].c, directed_cases[i].v, directed_cases[i].alt);
      if (directed_cases[i].text.len() == 0) begin
        predict_chars(directed_cases[i].c, directed_cases[i].v, directed_cases[i].alt);
      end else begin
        for (k = 0; k < directed_cases[i].text.len(); k++) begin
          expected_chars.push_back('{ch: 7'(directed_cases[i].text[k]),
                                     last: (k == directed_cases[i].text.len() - 1)});
        end
      end
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 23;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      rc = ifa_pkg::cmd_t'($urandom_range(3));
      rv = pick_value();
      ra = 1'($urandom_range(1));
      send_format(rc, rv, ra);
      predict_chars(rc, rv, ra);
    end
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("formatted %0d signed, %0d unsigned, %0d hex, %0d pointer values",
             items_per_cmd[ifa_pkg::CMD_SDEC], items_per_cmd[ifa_pkg::CMD_UDEC],
             items_per_cmd[ifa_pkg::CMD_HEX], items_per_cmd[ifa_pkg::CMD_PTR]);
    $display("%0d character beats checked under three stall patterns, %0d mismatches",
             chars_checked, mismatches);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
